/* rtl/ltdd_pkg.sv */
package ltdd_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int TXN_BITS    = 16;
    localparam int LOCK_BITS   = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    localparam int SOFT_MODE_VAL = 1;
    localparam int HARD_MODE_VAL = 2;

    localparam logic [1:0] KIND_SOFT    = 2'd0;
    localparam logic [1:0] KIND_HARD    = 2'd1;
    localparam logic [1:0] KIND_ACQUIRE = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd1;
    localparam logic [1:0] ERR_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] transaction_id;
        logic [15:0] lock_id;
    } req_t;

    typedef struct packed {
        logic       deadlock;
        logic [1:0] error_code;
    } rsp_t;
endpackage

/* rtl/lock_table_deadlock_detector_unit.sv */
// Channel | Signals                     | Payload
// in      | in_valid, in_stall          | ltdd_pkg::req_t
// out     | out_valid, out_stall        | ltdd_pkg::rsp_t
//
// One item at a time. Request/acquire: a lookup state, then reduction of
// up to 2*TABLE_DEPTH+1 passes (each edge changes at most twice) of one visit
// a cycle, each visit compared against all entries through one shared
// compare row, then a done state to present the result.
// Release: lookup, one shift step per shifted entry plus one, then the result.
// Reset clears the count and control.
// A result held under out_stall blocks new input until it is taken.
module lock_table_deadlock_detector_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ltdd_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output ltdd_pkg::rsp_t out_data
);
    import ltdd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1;
    localparam logic [2:0] ST_REDUCE = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [TXN_BITS-1:0]  tx_mem [TABLE_DEPTH];
    logic [LOCK_BITS-1:0] lk_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] held_reg, hard_reg, alive_reg, wheld_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [2:0] state_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic changed_reg;
    req_t req_reg;
    rsp_t rsp_reg;
    logic out_valid_reg;

    logic [TABLE_DEPTH-1:0] match, blk_held, blk_wait;
    logic found;
    logic [IDX_BITS-1:0] pos;
    logic [TXN_BITS-1:0] rq_tx;
    logic [LOCK_BITS-1:0] rq_lk;
    logic last_visit, dl;
    logic visit_change;

    assign rq_tx = TXN_BITS'(req_reg.transaction_id);
    assign rq_lk = LOCK_BITS'(req_reg.lock_id);

    always_comb
    begin
        found = 1'b0;
        pos = '0;
        dl = 1'b0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            match[j] = (CNT_BITS'(j) < count_reg) && tx_mem[j] == rq_tx
                && lk_mem[j] == rq_lk;
            blk_held[j] = (IDX_BITS'(j) != idx_reg) && alive_reg[j] && !wheld_reg[j]
                && tx_mem[j] == tx_mem[idx_reg];
            blk_wait[j] = (IDX_BITS'(j) != idx_reg) && alive_reg[j] && wheld_reg[j]
                && lk_mem[j] == lk_mem[idx_reg];
            if (alive_reg[j] && hard_reg[j])
                dl = 1'b1;
        end
        for (int j = TABLE_DEPTH - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                found = 1'b1;
                pos = IDX_BITS'(j);
            end
        end
    end

    assign last_visit = (CNT_BITS'(idx_reg) + 1'b1) >= count_reg;
    assign visit_change = alive_reg[idx_reg]
        && (wheld_reg[idx_reg] ? (blk_held == '0) : (blk_wait == '0));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !in_stall
            && in_data.kind != KIND_ACQUIRE && in_data.kind != KIND_RELEASE
            && count_reg < CNT_BITS'(TABLE_DEPTH))
        begin
            tx_mem[count_reg[IDX_BITS-1:0]] <= TXN_BITS'(in_data.transaction_id);
            lk_mem[count_reg[IDX_BITS-1:0]] <= LOCK_BITS'(in_data.lock_id);
        end
        else if (state_reg == ST_SHIFT && !last_visit)
        begin
            tx_mem[idx_reg] <= tx_mem[idx_reg + 1'b1];
            lk_mem[idx_reg] <= lk_mem[idx_reg + 1'b1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            changed_reg <= 1'b0;
            held_reg <= '0;
            hard_reg <= '0;
            alive_reg <= '0;
            wheld_reg <= '0;
            req_reg <= '0;
            rsp_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        req_reg <= in_data;
                        if (in_data.kind == KIND_SOFT || in_data.kind == KIND_HARD)
                        begin
                            if (count_reg >= CNT_BITS'(TABLE_DEPTH))
                            begin
                                rsp_reg <= '{deadlock: 1'b0, error_code: ERR_FULL};
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                held_reg[count_reg[IDX_BITS-1:0]] <= 1'b0;
                                hard_reg[count_reg[IDX_BITS-1:0]] <=
                                    (in_data.kind == KIND_HARD);
                                count_reg <= count_reg + 1'b1;
                                state_reg <= ST_FIND;
                            end
                        end
                        else
                            state_reg <= ST_FIND;
                    end
                end
                ST_FIND:
                begin
                    if (req_reg.kind != KIND_SOFT && req_reg.kind != KIND_HARD && !found)
                    begin
                        rsp_reg <= '{deadlock: 1'b0, error_code: ERR_NOT_FOUND};
                        state_reg <= ST_DONE;
                    end
                    else if (req_reg.kind == KIND_RELEASE)
                    begin
                        idx_reg <= pos;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        for (int j = 0; j < TABLE_DEPTH; j++)
                        begin
                            alive_reg[j] <= CNT_BITS'(j) < count_reg;
                            wheld_reg[j] <= held_reg[j] ||
                                (req_reg.kind == KIND_ACQUIRE && IDX_BITS'(j) == pos);
                        end
                        if (req_reg.kind == KIND_ACQUIRE)
                            held_reg[pos] <= 1'b1;
                        idx_reg <= '0;
                        changed_reg <= 1'b0;
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE:
                begin
                    if (alive_reg[idx_reg])
                    begin
                        if (wheld_reg[idx_reg])
                        begin
                            if (blk_held == '0)
                                alive_reg[idx_reg] <= 1'b0;
                        end
                        else if (blk_wait == '0)
                            wheld_reg[idx_reg] <= 1'b1;
                    end
                    if (last_visit)
                    begin
                        idx_reg <= '0;
                        changed_reg <= 1'b0;
                        if (!(changed_reg || visit_change))
                        begin
                            rsp_reg <= '{deadlock: dl, error_code: ERR_OK};
                            state_reg <= ST_DONE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        changed_reg <= changed_reg || visit_change;
                    end
                end
                ST_SHIFT:
                begin
                    if (last_visit)
                    begin
                        count_reg <= count_reg - 1'b1;
                        rsp_reg <= '{deadlock: 1'b0, error_code: ERR_OK};
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        held_reg[idx_reg] <= held_reg[idx_reg + 1'b1];
                        hard_reg[idx_reg] <= hard_reg[idx_reg + 1'b1];
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data = rsp_reg;
endmodule

/* rtl/ltdd_checker.sv */
module ltdd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input ltdd_pkg::req_t in_data,
    input logic           out_valid,
    input logic           out_stall,
    input ltdd_pkg::rsp_t out_data
);
    import ltdd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.error_code <= ERR_FULL)
        else $error("bad error code");

    a_err_no_dl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != ERR_OK |-> !out_data.deadlock)
        else $error("deadlock flagged with error");
endmodule

bind lock_table_deadlock_detector_unit ltdd_checker u_ltdd_checker (.*);
